// ===== hdl/sorted_min_priority_queue_defines.svh =====
// assertion macros used by the queue controller rtl
`ifndef SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
// antecedent holds, consequent holds in the same cycle
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spq assertion failed");
// antecedent holds, consequent holds in the next cycle
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int OCC_W        = 5;
	localparam int IN_W         = 40;
	localparam int OUT_W        = 40;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK_CHK,
		S_WALK_CMP,
		S_POP_DAT,
		S_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    rd_walk;
		logic    wr_shift;
		logic    wr_key;
		logic    rd_top;
		logic    pop;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_remove;
		logic empty;
		logic full;
		logic j_zero;
		logic less;
	} stat_t;

endpackage

// ===== hdl/spq_ram.sv =====
`timescale 1ns / 1ps
module spq_ram #(
	parameter int WIDTH = spq_pkg::KEY_W,
	parameter int DEPTH = spq_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/spq_datapath.sv =====
`timescale 1ns / 1ps
module spq_datapath #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_opcode,
	input  logic signed [spq_pkg::KEY_W-1:0]   in_key,
	input  spq_pkg::cmd_t                      cmd,
	output spq_pkg::stat_t                     stat,
	output logic [1:0]                         out_status,
	output logic signed [spq_pkg::KEY_W-1:0]   out_key,
	output logic [spq_pkg::OCC_W-1:0]          out_occ
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                             opcode_q;
	logic signed [spq_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    j_q;
	logic [spq_pkg::KEY_W-1:0]        removed_q;
	spq_pkg::status_t                 status_q;
	logic [spq_pkg::KEY_W-1:0]        key_out_q;
	logic [spq_pkg::OCC_W-1:0]        occ_q;

	logic [CW-1:0]             j_m1;
	logic [CW-1:0]             cnt_m1;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [spq_pkg::KEY_W-1:0] ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [spq_pkg::KEY_W-1:0] ram_rdata;

	assign j_m1   = j_q - 1'b1;
	assign cnt_m1 = count_q - 1'b1;

	// keys stored descending, smallest at count-1
	assign ram_we    = cmd.wr_shift | cmd.wr_key;
	assign ram_waddr = j_q[AW-1:0];
	assign ram_wdata = cmd.wr_shift ? ram_rdata : key_q;
	assign ram_re    = cmd.rd_walk | cmd.rd_top;
	assign ram_raddr = cmd.rd_top ? cnt_m1[AW-1:0] : j_m1[AW-1:0];

	spq_ram #(
		.WIDTH (spq_pkg::KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= in_opcode;
			key_q    <= in_key;
		end
		if (cmd.load) begin
			removed_q <= '0;
		end else if (cmd.pop) begin
			removed_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			status_q  <= cmd.out_status;
			key_out_q <= removed_q;
			occ_q     <= spq_pkg::OCC_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.wr_key) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= cnt_m1;
			end
			if (cmd.load) begin
				j_q <= count_q;
			end else if (cmd.wr_shift) begin
				j_q <= j_m1;
			end
		end
	end

	assign stat.op_remove = (opcode_q == spq_pkg::OP_REMOVE);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.j_zero    = (j_q == '0);
	assign stat.less      = ($signed(ram_rdata) < key_q);

	assign out_status = status_q;
	assign out_key    = key_out_q;
	assign out_occ    = occ_q;

endmodule

// ===== hdl/spq_ctrl.sv =====
`timescale 1ns / 1ps
`include "sorted_min_priority_queue_defines.svh"
module spq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  spq_pkg::stat_t stat,
	output spq_pkg::cmd_t  cmd
);

	spq_pkg::state_t  state_q, state_d;
	spq_pkg::status_t st_q, st_d;
	logic             out_valid_q;
	logic             fin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_IDLE;
			st_q        <= spq_pkg::ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		st_d           = st_q;
		cmd            = '0;
		cmd.out_status = st_q;
		s_tready       = 1'b0;
		case (state_q)
			spq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = spq_pkg::S_DECIDE;
				end
			end
			spq_pkg::S_DECIDE: begin
				st_d = spq_pkg::ST_DONE;
				if (!stat.op_remove) begin
					if (stat.full) begin
						st_d    = spq_pkg::ST_FULL;
						state_d = spq_pkg::S_FIN;
					end else begin
						state_d = spq_pkg::S_WALK_CHK;
					end
				end else if (stat.empty) begin
					st_d    = spq_pkg::ST_EMPTY;
					state_d = spq_pkg::S_FIN;
				end else begin
					cmd.rd_top = 1'b1;
					state_d    = spq_pkg::S_POP_DAT;
				end
			end
			spq_pkg::S_WALK_CHK: begin
				if (stat.j_zero) begin
					cmd.wr_key = 1'b1;
					state_d    = spq_pkg::S_FIN;
				end else begin
					cmd.rd_walk = 1'b1;
					state_d     = spq_pkg::S_WALK_CMP;
				end
			end
			spq_pkg::S_WALK_CMP: begin
				if (stat.less) begin
					cmd.wr_shift = 1'b1;
					state_d      = spq_pkg::S_WALK_CHK;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = spq_pkg::S_FIN;
				end
			end
			spq_pkg::S_POP_DAT: begin
				cmd.pop = 1'b1;
				state_d = spq_pkg::S_FIN;
			end
			spq_pkg::S_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	// result ready but the previous one still waits downstream
	assign fin_stall = (state_q == spq_pkg::S_FIN) && out_valid_q && !m_tready;

	`SPQ_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, !out_valid_q || m_tready)
	`SPQ_ASSERT_NXT(a_fin_hold, clk, arst_n, fin_stall, state_q == spq_pkg::S_FIN)
	`SPQ_ASSERT_IMP(a_no_insert_full, clk, arst_n, cmd.wr_key, !stat.full)
	`SPQ_ASSERT_IMP(a_no_pop_empty, clk, arst_n, cmd.pop, !stat.empty)

endmodule

// ===== hdl/sorted_min_priority_queue.sv =====
`timescale 1ns / 1ps
// reject: decide, fin; remove: decide, pop, fin; insert walks each displaced (smaller) key
// an insert above every stored key skips the last compare; into an empty queue, no walk
// one item at a time: the next is accepted in the cycle after the result is registered
// the single read port of the key ram sets the walk: read a key, then compare it
// reset: arst_n low clears the key count, the controller state and the output valid
// reset: key ram contents are not cleared, only entries below the count are read
module sorted_min_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item in
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // opcode[0], key_in[32:1], zero fill above
	// item out
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [spq_pkg::OUT_W-1:0] m_tdata   // status[1:0], key_out[33:2], occupancy[38:34]
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;

	logic                             in_opcode;
	logic signed [spq_pkg::KEY_W-1:0] in_key;
	logic [1:0]                       out_status;
	logic signed [spq_pkg::KEY_W-1:0] out_key;
	logic [spq_pkg::OCC_W-1:0]        out_occ;

	// unpack the input item, opcode in the low bit
	assign in_opcode = s_tdata[0];
	assign in_key    = s_tdata[spq_pkg::KEY_W:1];

	// state machine: accept, dispatch, insertion walk or pop, result hand-off
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key ram (kept descending so the smallest sits at count-1), count, walk index,
	// comparator and the output register
	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_opcode  (in_opcode),
		.in_key     (in_key),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (out_status),
		.out_key    (out_key),
		.out_occ    (out_occ)
	);

	// pack the result item, zero fill to whole bytes
	assign m_tdata = {
		{(spq_pkg::OUT_W - spq_pkg::OCC_W - spq_pkg::KEY_W - 2){1'b0}},
		out_occ,
		out_key,
		out_status
	};

endmodule
